// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define OSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define OSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define OSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define OSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/oss_pkg.sv =====
// ---------------------------------------------------------------------------
// oss_pkg
// Shared constants, types and request codes of the order statistic set.
// ---------------------------------------------------------------------------
package oss_pkg;

  localparam int CAPACITY = 256;
  localparam int CNT_W    = 9;
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;

  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [KIND_W-1:0]       kind_t;

  localparam kind_t KIND_INSERT = 3'd0;
  localparam kind_t KIND_ERASE  = 3'd1;
  localparam kind_t KIND_MEMBER = 3'd2;
  localparam kind_t KIND_LOWER  = 3'd3;
  localparam kind_t KIND_UPPER  = 3'd4;
  localparam kind_t KIND_SELECT = 3'd5;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against key
    logic ins;     // open a slot at the first not-below cell and write key
    logic del;     // close the slot at the first not-below cell
    key_t key;
    cnt_t pos;
    cnt_t count;
  } cell_ctl_t;

  // Flags a cell reports back.
  typedef struct packed {
    logic lt;  // stored key is valid and below the request key
    logic eq;  // stored key is valid and equal to the request key
  } cell_stat_t;

endpackage

// ===== rtl/core/oss_if.sv =====
// ---------------------------------------------------------------------------
// oss_req_if / oss_rsp_if
// Valid/ready channels for requests and replies of the order statistic set.
// ---------------------------------------------------------------------------
interface oss_req_if;
  logic                valid;
  logic                ready;
  oss_pkg::kind_t      kind;
  oss_pkg::key_t       value;
  oss_pkg::cnt_t       position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface oss_rsp_if;
  logic                valid;
  logic                ready;
  logic                ok;
  oss_pkg::cnt_t       rank;
  oss_pkg::key_t       element;
  oss_pkg::cnt_t       set_size;

  modport source (output valid, ok, rank, element, set_size, input ready);
  modport sink   (input valid, ok, rank, element, set_size, output ready);
endinterface

// ===== rtl/core/order_statistic_set.sv =====
// ---------------------------------------------------------------------------
// order_statistic_set
// Sorted set of distinct signed 32-bit keys with insert, erase, membership,
// lower/upper rank and select-by-position, built as a row of key cells.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Word contents                        Handshake
//  -------  ---  -----------------------------------  -----------------
//  in_ch    in   kind, value, position                valid/ready
//  out_ch   out  ok, rank, element, set_size          valid/ready
//
//  A word is taken only when the block is idle: the compare state latches the
//  compare flags of all cells, then the execute state encodes the ranks, shifts
//  the cells and loads the reply; no new word is taken before that commit.
//  Reset clears the entry count and the control state; cell keys stay as is.
//  A stalled reply holds the block in its execute state; one finished reply can
//  wait while the next word is accepted and compared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module order_statistic_set (
  input  logic      clk,
  input  logic      rst_n,
  oss_req_if.sink   in_ch,
  oss_rsp_if.source out_ch
);

  localparam int N = oss_pkg::CAPACITY;

  // Sequencer: idle waits for a word, compare latches flags, execute commits.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_EXE  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  oss_pkg::kind_t req_kind_r;
  oss_pkg::key_t  req_value_r;
  oss_pkg::cnt_t  req_pos_r;

  oss_pkg::cnt_t  count_r, count_nxt;

  // Reply register.
  logic           out_valid_r;
  logic           out_ok_r;
  oss_pkg::cnt_t  out_rank_r;
  oss_pkg::key_t  out_element_r;
  oss_pkg::cnt_t  out_size_r;

  logic           in_fire;
  logic           exe_go;

  oss_pkg::cell_ctl_t  cell_ctl;
  oss_pkg::key_t       cell_key   [N];
  oss_pkg::key_t       cell_left  [N];
  oss_pkg::key_t       cell_right [N];
  oss_pkg::key_t       cell_sel   [N];
  oss_pkg::cell_stat_t cell_stat  [N];
  logic [N-1:0]        lt_vec;
  logic [N-1:0]        le_vec;
  logic [N-1:0]        eq_vec;
  logic [N-1:0]        left_lt;

  oss_pkg::cnt_t  rank_lo;
  oss_pkg::cnt_t  rank_hi;
  oss_pkg::key_t  sel_key;
  logic           present;
  logic           full;
  logic           do_ins;
  logic           do_del;

  logic           rsp_ok;
  oss_pkg::cnt_t  rsp_rank;
  oss_pkg::key_t  rsp_element;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // The commit happens only when the reply register can take the result.
  assign exe_go      = (state_r == ST_EXE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXE;
      end
      ST_EXE: begin
        if (exe_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind_r  <= in_ch.kind;
      req_value_r <= in_ch.value;
      req_pos_r   <= in_ch.position;
    end
  end

  // Cell row. Cell 0 has no lower neighbor: it behaves as if a smaller key
  // sat to its left, so it takes the new key when it is the insert point.
  // The top cell keeps its own key when the row shifts down.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      lt_vec[i]  = cell_stat[i].lt;
      eq_vec[i]  = cell_stat[i].eq;
      le_vec[i]  = cell_stat[i].lt | cell_stat[i].eq;
      left_lt[i] = (i == 0) ? 1'b1 : cell_stat[(i == 0) ? 0 : i-1].lt;
      cell_left[i]  = (i == 0) ? cell_key[0] : cell_key[(i == 0) ? 0 : i-1];
      cell_right[i] = (i == N-1) ? cell_key[N-1] : cell_key[(i == N-1) ? N-1 : i+1];
    end
  end

  assign cell_ctl.cmp_en = (state_r == ST_CMP);
  assign cell_ctl.ins    = do_ins;
  assign cell_ctl.del    = do_del;
  assign cell_ctl.key    = req_value_r;
  assign cell_ctl.pos    = req_pos_r;
  assign cell_ctl.count  = count_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    oss_cell u_cell (
      .clk         (clk),
      .idx_i       (oss_pkg::cnt_t'(g)),
      .ctl_i       (cell_ctl),
      .left_key_i  (cell_left[g]),
      .left_lt_i   (left_lt[g]),
      .right_key_i (cell_right[g]),
      .key_o       (cell_key[g]),
      .stat_o      (cell_stat[g]),
      .sel_key_o   (cell_sel[g])
    );
  end

  // Ranks come from the thermometer of below and at-most flags; the set is
  // sorted, so each flag vector is a run of ones from cell 0 upward.
  oss_therm_enc u_enc_lo (
    .therm_i (lt_vec),
    .count_o (rank_lo)
  );

  oss_therm_enc u_enc_hi (
    .therm_i (le_vec),
    .count_o (rank_hi)
  );

  // At most one cell matches the position, so an OR gathers its key.
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < N; i++) begin
      sel_key = sel_key | cell_sel[i];
    end
  end

  assign present = |eq_vec;
  assign full    = (count_r == oss_pkg::cnt_t'(N));
  assign do_ins  = exe_go && (req_kind_r == oss_pkg::KIND_INSERT) && !present && !full;
  assign do_del  = exe_go && (req_kind_r == oss_pkg::KIND_ERASE) && present;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + oss_pkg::cnt_t'(1);
    end else if (do_del) begin
      count_nxt = count_r - oss_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    rsp_ok      = 1'b0;
    rsp_rank    = '0;
    rsp_element = '0;
    case (req_kind_r)
      oss_pkg::KIND_INSERT: begin
        rsp_ok = present || !full;
      end
      oss_pkg::KIND_ERASE: begin
        rsp_ok = present;
      end
      oss_pkg::KIND_MEMBER: begin
        rsp_ok = present;
      end
      oss_pkg::KIND_LOWER: begin
        rsp_ok   = 1'b1;
        rsp_rank = rank_lo;
      end
      oss_pkg::KIND_UPPER: begin
        rsp_ok   = 1'b1;
        rsp_rank = rank_hi;
      end
      oss_pkg::KIND_SELECT: begin
        if (req_pos_r < count_r) begin
          rsp_ok      = 1'b1;
          rsp_element = sel_key;
        end else begin
          rsp_element = '1;
        end
      end
      default: begin
        rsp_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exe_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_go) begin
      out_ok_r      <= rsp_ok;
      out_rank_r    <= rsp_rank;
      out_element_r <= rsp_element;
      out_size_r    <= count_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.ok       = out_ok_r;
  assign out_ch.rank     = out_rank_r;
  assign out_ch.element  = out_element_r;
  assign out_ch.set_size = out_size_r;

  // The entry count never passes the capacity.
  `OSS_ASSERT(a_count_cap, clk, rst_n, count_r <= oss_pkg::cnt_t'(N), "count above capacity")

  // The below flags of a sorted row form a run of ones from cell 0.
  `OSS_ASSERT_IMP(a_lt_therm, clk, rst_n, state_r == ST_EXE, $onehot({1'b0, lt_vec} + {{N{1'b0}}, 1'b1}), "below flags not a thermometer")

  // Keys are distinct, so at most one cell can match.
  `OSS_ASSERT_IMP(a_eq_single, clk, rst_n, state_r == ST_EXE, $onehot0(eq_vec), "duplicate key in set")

  // The count changes only when a word is committed.
  `OSS_ASSERT_IMP(a_count_step, clk, rst_n, $past(rst_n) && !$past(exe_go), count_r == $past(count_r), "count changed without a commit")

endmodule

// ===== rtl/core/oss_cell.sv =====
// ---------------------------------------------------------------------------
// oss_cell
// One slot of the sorted array: holds a key, compares it with the broadcast
// key and shifts toward either neighbor on insert or erase.
// ---------------------------------------------------------------------------
module oss_cell (
  input  logic                  clk,
  input  oss_pkg::cnt_t         idx_i,
  input  oss_pkg::cell_ctl_t    ctl_i,
  input  oss_pkg::key_t         left_key_i,
  input  logic                  left_lt_i,
  input  oss_pkg::key_t         right_key_i,
  output oss_pkg::key_t         key_o,
  output oss_pkg::cell_stat_t   stat_o,
  output oss_pkg::key_t         sel_key_o
);

  oss_pkg::key_t key_r;
  oss_pkg::key_t key_nxt;
  logic          lt_r;
  logic          eq_r;
  logic          slot_valid;

  assign slot_valid = (idx_i < ctl_i.count);

  always_comb begin
    key_nxt = key_r;
    if (ctl_i.ins && !lt_r) begin
      key_nxt = left_lt_i ? ctl_i.key : left_key_i;
    end else if (ctl_i.del && !lt_r) begin
      key_nxt = right_key_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl_i.cmp_en) begin
      lt_r <= slot_valid && ($signed(key_r) < $signed(ctl_i.key));
      eq_r <= slot_valid && (key_r == ctl_i.key);
    end
  end

  assign key_o     = key_r;
  assign stat_o.lt = lt_r;
  assign stat_o.eq = eq_r;
  assign sel_key_o = (ctl_i.pos == idx_i) ? key_r : '0;

endmodule

// ===== rtl/core/oss_therm_enc.sv =====
// ---------------------------------------------------------------------------
// oss_therm_enc
// Converts a thermometer vector (ones from bit 0 upward) into its count by
// locating the single edge and OR-encoding its position.
// ---------------------------------------------------------------------------
module oss_therm_enc (
  input  logic [oss_pkg::CAPACITY-1:0] therm_i,
  output oss_pkg::cnt_t                count_o
);

  logic [oss_pkg::CAPACITY:0] edge_bits;

  always_comb begin
    edge_bits[0] = ~therm_i[0];
    for (int i = 1; i < oss_pkg::CAPACITY; i++) begin
      edge_bits[i] = therm_i[i-1] & ~therm_i[i];
    end
    edge_bits[oss_pkg::CAPACITY] = therm_i[oss_pkg::CAPACITY-1];
  end

  always_comb begin
    count_o = '0;
    for (int i = 0; i <= oss_pkg::CAPACITY; i++) begin
      if (edge_bits[i]) begin
        count_o = count_o | oss_pkg::cnt_t'(i);
      end
    end
  end

endmodule
